>>> rtl/pic_pkg.sv
// Shared types, register indexes and constants of the periodic image contact check.
`default_nettype none

package pic_pkg;

	// Largest periodic shift per axis that the hardware supports by default.
	localparam int MAX_IMAGE_RANGE_DEF = 4;

	// Saturation value of every squared distance and partial sum.
	localparam logic [62:0] DIST_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

	// Drain wait from the last image issued until the running minimum is final.
	localparam logic [1:0] DRAIN_LAST = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] REG_BOX_LEN_X   = 3'd0;
	localparam logic [2:0] REG_BOX_LEN_Y   = 3'd1;
	localparam logic [2:0] REG_BOX_LEN_Z   = 3'd2;
	localparam logic [2:0] REG_CUTOFF_SQ   = 3'd3;
	localparam logic [2:0] REG_IMAGE_RANGE = 3'd4;

	typedef struct packed {
		logic [30:0] box_len_x;
		logic [30:0] box_len_y;
		logic [30:0] box_len_z;
		logic [62:0] cutoff_sq;
		logic [2:0]  image_range;
	} cfg_t;

	typedef struct packed {
		logic [15:0]        tag_a;
		logic [15:0]        tag_b;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [31:0] bx;
		logic signed [31:0] by_coord;
		logic signed [31:0] bz;
	} in_beat_t;

	typedef struct packed {
		logic [15:0] out_tag_a;
		logic [15:0] out_tag_b;
		logic [62:0] min_dist_sq;
		logic        in_contact;
	} out_beat_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic load;       // capture a new pair and reset the running minimum
		logic issue;      // evaluate the image at the current offsets
		logic img_valid;  // the issued image is not the zero shift
		logic wrap_k;     // z shift wraps to -R
		logic wrap_j;     // y shift wraps to -R as well
		logic publish;    // load the result register
	} dp_cmd_t;

endpackage

`default_nettype wire

>>> rtl/pic_cfg.sv
// Configuration register file of the periodic image contact check.
`default_nettype none

module pic_cfg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [62:0]   cfg_wdata,
	output pic_pkg::cfg_t      cfg
);
	import pic_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_len_x   <= '0;
			cfg_q.box_len_y   <= '0;
			cfg_q.box_len_z   <= '0;
			cfg_q.cutoff_sq   <= '0;
			cfg_q.image_range <= 3'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BOX_LEN_X:   cfg_q.box_len_x   <= cfg_wdata[30:0];
				REG_BOX_LEN_Y:   cfg_q.box_len_y   <= cfg_wdata[30:0];
				REG_BOX_LEN_Z:   cfg_q.box_len_z   <= cfg_wdata[30:0];
				REG_CUTOFF_SQ:   cfg_q.cutoff_sq   <= cfg_wdata;
				REG_IMAGE_RANGE: cfg_q.image_range <= cfg_wdata[2:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> rtl/pic_dp.sv
// Datapath: image offsets, per-axis squares, saturating sum and running minimum.
`default_nettype none

module pic_dp #(
	parameter int MAX_RANGE = pic_pkg::MAX_IMAGE_RANGE_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire pic_pkg::cfg_t                   cfg,
	input  wire pic_pkg::in_beat_t               item,
	input  wire pic_pkg::dp_cmd_t                cmd,
	output logic [$clog2(MAX_RANGE+1)-1:0]       range_eff,
	output pic_pkg::out_beat_t                   result
);
	import pic_pkg::*;

	localparam int RW = $clog2(MAX_RANGE + 1);
	// Offsets reach MAX_RANGE box lengths, each below 2^31.
	localparam int OW = 33 + RW;
	localparam int DW = OW + 1;
	localparam logic [2:0] MAX_R3 = 3'(MAX_RANGE);

	logic [30:0]          len [3];
	logic [31:0]          ca [3];
	logic [31:0]          cb [3];
	logic [OW-1:0]        rl [3];
	logic signed [OW-1:0] nbase [3];
	logic [2:0]           r_sat;

	logic signed [32:0]   diff_q [3];
	logic signed [OW-1:0] base_q [3];
	logic signed [OW-1:0] off_q [3];
	logic [15:0]          tag_a_q;
	logic [15:0]          tag_b_q;

	logic signed [DW-1:0] d_s1 [3];
	logic                 v_s1;
	logic signed [32:0]   lo [3];
	logic signed [65:0]   prod [3];
	logic                 fits [3];
	logic [62:0]          sq [3];
	logic [62:0]          sq_s2 [3];
	logic                 v_s2;
	logic [64:0]          sum;
	logic [62:0]          dist_s3;
	logic                 v_s3;
	logic [62:0]          best_q;
	logic                 tried_q;
	out_beat_t            result_q;

	assign r_sat     = (cfg.image_range > MAX_R3) ? MAX_R3 : cfg.image_range;
	assign range_eff = RW'(r_sat);

	assign len[0] = cfg.box_len_x;
	assign len[1] = cfg.box_len_y;
	assign len[2] = cfg.box_len_z;
	assign ca[0]  = item.ax;
	assign ca[1]  = item.ay;
	assign ca[2]  = item.az;
	assign cb[0]  = item.bx;
	assign cb[1]  = item.by_coord;
	assign cb[2]  = item.bz;

	// Starting offset of each axis is -R box lengths; R is at most seven.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			rl[a]    = OW'(range_eff) * OW'(len[a]);
			nbase[a] = signed'(OW'(0) - rl[a]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int a = 0; a < 3; a++) begin
				diff_q[a] <= signed'({cb[a][31], cb[a]}) - signed'({ca[a][31], ca[a]});
				base_q[a] <= nbase[a];
				off_q[a]  <= nbase[a];
			end
			tag_a_q <= item.tag_a;
			tag_b_q <= item.tag_b;
		end else if (cmd.issue) begin
			// z steps every image, y when z wraps, x when y wraps too.
			if (cmd.wrap_k) begin
				off_q[2] <= base_q[2];
				if (cmd.wrap_j) begin
					off_q[1] <= base_q[1];
					off_q[0] <= off_q[0] + signed'(OW'(len[0]));
				end else begin
					off_q[1] <= off_q[1] + signed'(OW'(len[1]));
				end
			end else begin
				off_q[2] <= off_q[2] + signed'(OW'(len[2]));
			end
		end
	end

	// Stage 1: axis differences of the shifted image.
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			d_s1[a] <= DW'(diff_q[a]) + DW'(off_q[a]);
		end
	end

	// Stage 2: squares. A magnitude of 2^32 or more saturates outright.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			fits[a] = (d_s1[a][DW-1:32] == '0) ||
				((d_s1[a][DW-1:32] == '1) && (d_s1[a][31:0] != '0));
			lo[a]   = d_s1[a][32:0];
			prod[a] = lo[a] * lo[a];
			sq[a]   = (!fits[a] || prod[a][63]) ? DIST_MAX : prod[a][62:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			sq_s2[a] <= sq[a];
		end
	end

	// Stage 3: saturating sum of the three squares.
	assign sum = 65'(sq_s2[0]) + 65'(sq_s2[1]) + 65'(sq_s2[2]);

	always_ff @(posedge clk) begin
		dist_s3 <= (sum[64:63] != 2'b00) ? DIST_MAX : sum[62:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			tried_q <= 1'b0;
		end else begin
			v_s1 <= cmd.issue && cmd.img_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.load) begin
				tried_q <= 1'b0;
			end else if (v_s3) begin
				tried_q <= 1'b1;
			end
		end
	end

	// Stage 4: running minimum.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			best_q <= DIST_MAX;
		end else if (v_s3 && (dist_s3 < best_q)) begin
			best_q <= dist_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			result_q.out_tag_a   <= tag_a_q;
			result_q.out_tag_b   <= tag_b_q;
			result_q.min_dist_sq <= best_q;
			result_q.in_contact  <= tried_q && (best_q <= cfg.cutoff_sq);
		end
	end

	assign result = result_q;

endmodule

`default_nettype wire

>>> rtl/pic_ctrl.sv
// Sequencer: accepts a pair, walks the image shifts, drains the pipeline, hands over the result.
`default_nettype none

module pic_ctrl #(
	parameter int MAX_RANGE = pic_pkg::MAX_IMAGE_RANGE_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            item_valid,
	output logic                                 item_ready,
	output logic                                 result_valid,
	input  wire logic                            result_ready,
	input  wire logic [$clog2(MAX_RANGE+1)-1:0]  range_eff,
	output pic_pkg::dp_cmd_t                     cmd
);
	import pic_pkg::*;

	localparam int RW = $clog2(MAX_RANGE + 1);
	localparam int CW = $clog2(2 * MAX_RANGE + 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] i_q, j_q, k_q, i_d, j_d, k_d;
	logic [1:0]    drain_q, drain_d;
	logic          result_valid_q, result_valid_d;
	logic [CW-1:0] top;
	logic [CW-1:0] mid;

	// Shift counters run from 0 to 2R; the count R stands for a zero shift.
	assign top = CW'({range_eff, 1'b0});
	assign mid = CW'(range_eff);

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;

	always_comb begin
		cmd            = '0;
		state_d        = state_q;
		i_d            = i_q;
		j_d            = j_q;
		k_d            = k_q;
		drain_d        = drain_q;
		result_valid_d = result_valid_q && !result_ready;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					i_d      = '0;
					j_d      = '0;
					k_d      = '0;
					if (range_eff == RW'(0)) begin
						state_d = ST_DRAIN;
						drain_d = DRAIN_LAST;
					end else begin
						state_d = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				cmd.issue     = 1'b1;
				cmd.img_valid = !((i_q == mid) && (j_q == mid) && (k_q == mid));
				if (k_q == top) begin
					k_d        = '0;
					cmd.wrap_k = 1'b1;
					if (j_q == top) begin
						j_d        = '0;
						cmd.wrap_j = 1'b1;
						if (i_q == top) begin
							state_d = ST_DRAIN;
							drain_d = DRAIN_LAST;
						end else begin
							i_d = i_q + CW'(1);
						end
					end else begin
						j_d = j_q + CW'(1);
					end
				end else begin
					k_d = k_q + CW'(1);
				end
			end
			ST_DRAIN: begin
				if (drain_q != 2'd0) begin
					drain_d = drain_q - 2'd1;
				end else if (!result_valid_q || result_ready) begin
					cmd.publish    = 1'b1;
					result_valid_d = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			i_q            <= '0;
			j_q            <= '0;
			k_q            <= '0;
			drain_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			i_q            <= i_d;
			j_q            <= j_d;
			k_q            <= k_d;
			drain_q        <= drain_d;
			result_valid_q <= result_valid_d;
		end
	end

	a_run_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |=> state_q == ST_RUN || state_q == ST_DRAIN)
		else $error("image walk left for a state other than drain");

	a_drain_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DRAIN) ##1 (state_q == ST_DRAIN) |-> drain_q == DRAIN_LAST)
		else $error("drain started without a full pipeline wait");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !result_ready |-> !cmd.publish)
		else $error("result register loaded while a beat waits");

	a_publish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> result_valid_q && state_q == ST_IDLE)
		else $error("published result not offered");

endmodule

`default_nettype wire

>>> rtl/periodic_image_contact_check.sv
// Top level of the periodic image contact check.
//
// Input channel item_valid/item_ready/item carries one atom pair per beat:
// two tags and the Q15.16 coordinates of atoms A and B. Output channel
// result_valid/result_ready/result returns one beat per pair: the tags, the
// smallest squared distance over all non-zero periodic images (2^-32 nm^2,
// saturating) and the contact flag. The configuration port (cfg_we,
// cfg_index, cfg_wdata) writes the box lengths, squared cutoff and
// image range and must only be used while no pair is in flight.
// One image is evaluated per cycle by a single set of axis adders and
// multipliers. A pair of effective range R holds the sequencer while its
// image shifts are walked and the pipeline drains; the next pair is taken
// once its result is published, after the last image has passed through
// the four-stage datapath. A finished result waits in its output register,
// and the next pair is taken while it waits; only the publication of a
// second result stalls until the receiver takes the first. Reset clears the
// sequencer and the output valid, and sets the registers to their defaults.
`default_nettype none

module periodic_image_contact_check #(
	parameter int MAX_IMAGE_RANGE = pic_pkg::MAX_IMAGE_RANGE_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic [2:0]     cfg_index,
	input  wire logic [62:0]    cfg_wdata,
	input  wire logic           item_valid,
	output logic                item_ready,
	input  wire pic_pkg::in_beat_t item,
	output logic                result_valid,
	input  wire logic           result_ready,
	output pic_pkg::out_beat_t  result
);
	import pic_pkg::*;

	localparam int RW = $clog2(MAX_IMAGE_RANGE + 1);

	cfg_t          cfg;
	dp_cmd_t       cmd;
	logic [RW-1:0] range_eff;

	pic_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pic_ctrl #(
		.MAX_RANGE (MAX_IMAGE_RANGE)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.range_eff    (range_eff),
		.cmd          (cmd)
	);

	pic_dp #(
		.MAX_RANGE (MAX_IMAGE_RANGE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.item      (item),
		.cmd       (cmd),
		.range_eff (range_eff),
		.result    (result)
	);

endmodule

`default_nettype wire
